>>> design/pavw_pkg.sv
// Package for the piecewise affine vector warp.
// Holds shared types and constants; used by the top level and the testbench.
package pavw_pkg;
    localparam int unsigned WORDS_PER_MAP = 30;
    localparam logic [1:0] KIND_IDENT  = 2'd0;
    localparam logic [1:0] KIND_AFFINE = 2'd1;
    localparam logic [1:0] KIND_BOXES  = 2'd2;
    localparam logic [0:0] REG_KIND = 1'd0;
    localparam logic [0:0] REG_DIR  = 1'd1;
    localparam logic ACT_LOAD = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_MAC, S_DONE, S_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

>>> design/piecewise_affine_vector_warp.sv
// Top level of the piecewise affine vector warp.
// Uses pavw_pkg and pavw_row; holds the coefficient memory and the sequencer.
//
//  channel   direction  fields (tdata low bit up)
//  s_axis    in         action, map_index, word_index, word_value, in_x, in_y, in_z
//  m_axis    out        out_x, out_y, out_z, map_used, box_hit
//  cfg       in         i_cfg_we, i_cfg_index, i_cfg_data
//
// Loads can follow back to back while idle and no result is held.
// A transform reads its coefficients one word per cycle from the table, which
// sets the cost: each map reads nine matrix words, three offsets and six bounds,
// then waits for the compare pipe to drain. Box maps are tried in turn until
// one holds or the last is reached; identity is presented without any reads.
// Reset is synchronous, active low, and clears control state only; the table is
// undefined until written. A result waits in the output register while
// m_axis_tready is low, and no new request is taken until it leaves.
module piecewise_affine_vector_warp #(
    parameter int NUM_MAPS = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // action[0], map_index[4:1], word_index[9:5], word_value[41:10],
    // in_x[73:42], in_y[105:74], in_z[137:106], zero fill to 144 bits
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], map_used[99:96],
    // box_hit[100], zero fill to 104 bits
    output logic [103:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [1:0]   i_cfg_data
);
    localparam int DEPTH = NUM_MAPS * pavw_pkg::WORDS_PER_MAP;
    localparam int AW = $clog2(DEPTH);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd;

    logic [1:0] r_kind;
    logic       r_dir;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= pavw_pkg::KIND_IDENT;
            r_dir  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pavw_pkg::REG_KIND: r_kind <= i_cfg_data;
                pavw_pkg::REG_DIR:  r_dir  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    wire        in_act  = s_axis_tdata[0];
    wire [3:0]  in_map  = s_axis_tdata[4:1];
    wire [4:0]  in_word = s_axis_tdata[9:5];

    pavw_pkg::t_state r_st, n_st;
    logic [3:0]  r_map;       // map being evaluated
    logic [4:0]  r_step;      // read step 0..17 within a map
    logic [4:0]  r_dstep;     // step of the word now in r_rd
    logic        r_dv;
    logic signed [31:0] r_v [3];
    logic signed [31:0] r_res [3];
    logic        r_inb;
    logic        r_bx;        // boxes mode
    logic [103:0] r_out;
    logic        r_ov;

    wire accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_st == pavw_pkg::S_IDLE) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    // Step order: 0-8 matrix words (row major), 9-11 offsets, 12-17 bounds.
    // The backward matrix and offsets sit twelve words above the forward ones.
    wire [4:0] mbase = r_dir ? 5'd12 : 5'd0;
    logic [4:0] word_of;
    always_comb begin
        if (r_step < 5'd12) word_of = mbase + r_step;
        else if (r_step < 5'd18) word_of = r_step + 5'd12;
        else word_of = 5'd0;
    end
    wire [AW-1:0] rd_addr = AW'(r_map) * AW'(pavw_pkg::WORDS_PER_MAP) + AW'(word_of);
    wire [AW-1:0] wr_addr = AW'(in_map) * AW'(pavw_pkg::WORDS_PER_MAP) + AW'(in_word);

    always_ff @(posedge i_clk) begin
        if (accept && in_act == pavw_pkg::ACT_LOAD &&
            int'(in_map) < NUM_MAPS && in_word < 5'd30)
            r_mem[wr_addr] <= s_axis_tdata[41:10];
        r_rd <= r_mem[rd_addr];
    end

    // Column of the matrix word now in r_rd, which picks the vector element.
    logic [1:0]  d_col;
    always_comb begin
        case (r_dstep)
            5'd1, 5'd4, 5'd7: d_col = 2'd1;
            5'd2, 5'd5, 5'd8: d_col = 2'd2;
            default:          d_col = 2'd0;
        endcase
    end

    logic acc_clr, acc_en;
    logic signed [65:0] acc;
    assign acc_clr = r_dv && d_col == 2'd0 && r_dstep < 5'd9;
    assign acc_en  = r_dv && r_dstep < 5'd9;
    pavw_row u_row (
        .i_clk (i_clk),
        .i_clr (acc_clr),
        .i_en  (acc_en),
        .i_a   ($signed(r_rd)),
        .i_b   (r_v[d_col]),
        .o_acc (acc)
    );

    // Each word's product is registered in pavw_row and then added into the sum,
    // so row r is complete while dstep is 3r+4. The sum is rounded to Q16.16
    // with ties toward plus infinity and kept at full width.
    logic signed [65:0] rnd;
    assign rnd = (acc + 66'sd32768) >>> 16;

    // Offset row of the word now in r_rd, valid for dsteps 9..11.
    logic [1:0] off_row;
    assign off_row = 2'(r_dstep - 5'd9);

    // Bound compare source: forward tests results, backward tests input.
    logic [1:0] bk;
    logic signed [31:0] bval;
    always_comb begin
        bk = (r_dstep < 5'd15) ? 2'(r_dstep - 5'd12) : 2'(r_dstep - 5'd15);
        bval = r_dir ? r_v[bk] : r_res[bk];
    end

    logic signed [49:0] r_q [3]; // rounded sums awaiting offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= pavw_pkg::S_IDLE;
            r_ov <= 1'b0;
            r_dv <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            r_dv <= (r_st == pavw_pkg::S_READ);
            r_dstep <= r_step;
            if (accept && in_act != pavw_pkg::ACT_LOAD) begin
                r_v[0] <= s_axis_tdata[73:42];
                r_v[1] <= s_axis_tdata[105:74];
                r_v[2] <= s_axis_tdata[137:106];
                r_map  <= '0;
                r_step <= '0;
                r_bx   <= (r_kind == pavw_pkg::KIND_BOXES);
                r_inb  <= 1'b1;
            end
            if (r_st == pavw_pkg::S_READ) r_step <= r_step + 5'd1;
            if (r_dv && r_dstep == 5'd4) r_q[0] <= rnd[49:0];
            if (r_dv && r_dstep == 5'd7) r_q[1] <= rnd[49:0];
            if (r_dv && r_dstep == 5'd10) r_q[2] <= rnd[49:0];
            // Offsets arrive at dsteps 9..11, after their row's sum is held.
            if (r_dv && r_dstep >= 5'd9 && r_dstep < 5'd12)
                r_res[off_row] <= pavw_pkg::sat32(66'(r_q[off_row]) - 66'($signed(r_rd)));
            // Low bounds at dsteps 12..14, high bounds at 15..17, both inclusive.
            if (r_dv && r_dstep >= 5'd12 && r_dstep < 5'd18) begin
                if (r_dstep < 5'd15) begin
                    if (bval < $signed(r_rd)) r_inb <= 1'b0;
                end else if (bval > $signed(r_rd)) r_inb <= 1'b0;
            end
            if (n_st == pavw_pkg::S_READ && r_st == pavw_pkg::S_DONE) begin
                r_step <= '0;
                r_inb  <= 1'b1;
                r_map  <= r_map + 4'd1;
            end
            if (r_st == pavw_pkg::S_OUT) begin
                r_ov <= 1'b1;
                if (r_bx) begin
                    // The map that stopped the search, or the last map on fallback.
                    r_out <= {3'b0, r_inb, r_map, r_res[2], r_res[1], r_res[0]};
                end else if (r_kind == pavw_pkg::KIND_AFFINE) begin
                    r_out <= {3'b0, 1'b0, 4'd0, r_res[2], r_res[1], r_res[0]};
                end else begin
                    r_out <= {3'b0, 1'b0, 4'd0, r_v[2], r_v[1], r_v[0]};
                end
            end
        end
    end

    // The compare at dstep 17 is made in DONE; r_drain holds the decision back
    // until r_inb has taken the result of that compare.
    logic [1:0] r_drain;
    always_ff @(posedge i_clk) begin
        if (r_st != pavw_pkg::S_DONE) r_drain <= '0;
        else r_drain <= r_drain + 2'd1;
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            pavw_pkg::S_IDLE:
                if (accept && in_act != pavw_pkg::ACT_LOAD)
                    n_st = (r_kind == pavw_pkg::KIND_AFFINE ||
                            r_kind == pavw_pkg::KIND_BOXES)
                           ? pavw_pkg::S_READ : pavw_pkg::S_OUT;
            pavw_pkg::S_READ:
                if (r_step == 5'd17) n_st = pavw_pkg::S_DONE;
            pavw_pkg::S_DONE:
                if (r_drain == 2'd1) begin
                    if (!r_bx || r_inb || int'(r_map) == NUM_MAPS - 1)
                        n_st = pavw_pkg::S_OUT;
                    else n_st = pavw_pkg::S_READ;
                end
            pavw_pkg::S_OUT: n_st = pavw_pkg::S_IDLE;
            default: n_st = pavw_pkg::S_IDLE;
        endcase
    end

    // The read step counter stays within one map's words.
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == pavw_pkg::S_READ |-> r_step <= 5'd17)
        else $error("read step overran");
    // No request is taken while a result is still held.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !s_axis_tready)
        else $error("request taken over pending result");
    // The map under evaluation stays in range.
    a_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == pavw_pkg::S_READ |-> int'(r_map) < NUM_MAPS)
        else $error("map index out of range");
endmodule

>>> design/pavw_row.sv
// One row multiply step: a 32x32 signed product accumulated into a Q34.32 sum.
// Depends on nothing but its ports.
module pavw_row (
    input  logic               i_clk,
    input  logic               i_clr,
    input  logic               i_en,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [65:0] o_acc
);
    logic signed [63:0] r_prod;
    logic               r_pv;
    logic               r_pc;
    logic signed [65:0] r_acc;
    // The clear travels with its product, so the first product of a row
    // replaces the sum instead of wiping the last product of the row before.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_pv   <= i_en;
        r_pc   <= i_clr;
        if (r_pv) begin
            if (r_pc) begin
                r_acc <= 66'(r_prod);
            end else begin
                r_acc <= r_acc + 66'(r_prod);
            end
        end
    end
    assign o_acc = r_acc;
endmodule

>>> test/piecewise_affine_vector_warp_tb.sv
// Self-checking testbench for piecewise_affine_vector_warp.
// Drives load and transform requests with random gaps, predicts every result
// from its own model of the coefficient table, and checks the output stream.
`timescale 1ns / 100ps

module piecewise_affine_vector_warp_tb;
    localparam int MAPS       = 12;
    localparam int CYCLE_CAP  = 6_000_000;
    localparam logic ACT_WARP = 1'b1;

    // One request on the slave side.
    typedef struct {
        logic               action;
        logic [3:0]         map_sel;
        logic [4:0]         word_sel;
        logic signed [31:0] word_val;
        logic signed [31:0] vx, vy, vz;
        bit                 drain_first;
    } t_warp_req;

    // One transformed vector.
    typedef struct {
        logic signed [31:0] rx, ry, rz;
        logic [3:0]         map_used;
        logic               box_hit;
    } t_warp_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_vld = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_data = '0;
    logic         m_axis_tvalid;
    logic         m_rdy = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         cfg_we = 1'b0;
    logic         cfg_idx = 1'b0;
    logic [1:0]   cfg_val = 2'd0;

    t_warp_req pending_reqs[$];
    t_warp_res expected_vecs[$];
    t_warp_req in_flight;
    bit        took = 1'b0;
    bit        rst_done = 1'b0;
    bit        no_gaps = 1'b0;
    int        fail_count = 0;
    int        cycle_count = 0;

    // Shadow copy of the block's table and registers.
    logic signed [31:0] coef_shadow [MAPS][pavw_pkg::WORDS_PER_MAP];
    logic [1:0]         kind_shadow = pavw_pkg::KIND_IDENT;
    logic               dir_shadow = 1'b0;

    piecewise_affine_vector_warp #(.NUM_MAPS(MAPS)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_vld),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_rdy),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_idx),
        .i_cfg_data    (cfg_val)
    );

    always #5 i_clk = ~i_clk;

    // One row of M*v - b: the exact sum of products is rounded to Q16.16 with
    // ties toward plus infinity, then the offset comes off and the result saturates.
    function automatic logic signed [31:0] affine_row(int m, int mb, int ob, int r,
            logic signed [31:0] vx, logic signed [31:0] vy, logic signed [31:0] vz);
        logic signed [79:0] acc;
        acc = coef_shadow[m][mb + 3*r] * vx + coef_shadow[m][mb + 3*r + 1] * vy
            + coef_shadow[m][mb + 3*r + 2] * vz + 80'sd32768;
        acc = acc >>> 16;
        acc = acc - coef_shadow[m][ob + r];
        if (acc > 80'sd2147483647) return 32'sh7fffffff;
        if (acc < -80'sd2147483648) return 32'sh80000000;
        return acc[31:0];
    endfunction

    function automatic t_warp_res apply_map(int m, bit back, logic signed [31:0] vx,
            logic signed [31:0] vy, logic signed [31:0] vz);
        t_warp_res r;
        int mb, ob;
        mb = back ? 12 : 0;
        ob = back ? 21 : 9;
        r.rx = affine_row(m, mb, ob, 0, vx, vy, vz);
        r.ry = affine_row(m, mb, ob, 1, vx, vy, vz);
        r.rz = affine_row(m, mb, ob, 2, vx, vy, vz);
        r.map_used = 4'd0;
        r.box_hit = 1'b0;
        return r;
    endfunction

    // Box bounds are inclusive at both ends.
    function automatic bit box_holds(int m, logic signed [31:0] vx, logic signed [31:0] vy,
            logic signed [31:0] vz);
        return vx >= coef_shadow[m][24] && vx <= coef_shadow[m][27]
            && vy >= coef_shadow[m][25] && vy <= coef_shadow[m][28]
            && vz >= coef_shadow[m][26] && vz <= coef_shadow[m][29];
    endfunction

    // Applies one accepted request to the shadow state and queues its result.
    task automatic track_request(t_warp_req q);
        t_warp_res r;
        bit found;
        found = 1'b0;
        if (q.action == pavw_pkg::ACT_LOAD) begin
            // Loads outside the table are dropped by the block.
            if (q.map_sel < MAPS && q.word_sel < pavw_pkg::WORDS_PER_MAP)
                coef_shadow[q.map_sel][q.word_sel] = q.word_val;
            return;
        end
        if (kind_shadow == pavw_pkg::KIND_AFFINE) begin
            r = apply_map(0, dir_shadow, q.vx, q.vy, q.vz);
        end else if (kind_shadow == pavw_pkg::KIND_BOXES) begin
            if (dir_shadow) begin
                // Backward: the first box that holds the input picks the map.
                for (int m = 0; m < MAPS && !found; m++) begin
                    if (box_holds(m, q.vx, q.vy, q.vz)) begin
                        r = apply_map(m, 1'b1, q.vx, q.vy, q.vz);
                        r.map_used = 4'(m);
                        found = 1'b1;
                    end
                end
                if (!found) r = apply_map(MAPS - 1, 1'b1, q.vx, q.vy, q.vz);
            end else begin
                // Forward: each map in turn until its result lands in its own box.
                for (int m = 0; m < MAPS && !found; m++) begin
                    r = apply_map(m, 1'b0, q.vx, q.vy, q.vz);
                    if (box_holds(m, r.rx, r.ry, r.rz)) begin
                        r.map_used = 4'(m);
                        found = 1'b1;
                    end
                end
            end
            if (!found) r.map_used = 4'(MAPS - 1);
            r.box_hit = found;
        end else begin
            // Identity, and the unused kind that behaves like it.
            r.rx = q.vx;
            r.ry = q.vy;
            r.rz = q.vz;
            r.map_used = 4'd0;
            r.box_hit = 1'b0;
        end
        expected_vecs.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // Acceptance and output checking both happen at the rising edge.
    always @(posedge i_clk) begin
        t_warp_res want;
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("FAIL piecewise_affine_vector_warp");
            $finish;
        end else begin
            if (s_vld && s_axis_tready) begin
                took = 1'b1;
                track_request(in_flight);
            end
            if (rst_done && m_axis_tvalid && m_rdy) begin
                if (expected_vecs.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[31:0], 32'h0);
                end else begin
                    want = expected_vecs.pop_front();
                    if (m_axis_tdata[31:0] !== want.rx)
                        report_mismatch("out_x", m_axis_tdata[31:0], want.rx);
                    if (m_axis_tdata[63:32] !== want.ry)
                        report_mismatch("out_y", m_axis_tdata[63:32], want.ry);
                    if (m_axis_tdata[95:64] !== want.rz)
                        report_mismatch("out_z", m_axis_tdata[95:64], want.rz);
                    if (m_axis_tdata[99:96] !== want.map_used)
                        report_mismatch("map_used", 32'(m_axis_tdata[99:96]),
                                        32'(want.map_used));
                    if (m_axis_tdata[100] !== want.box_hit)
                        report_mismatch("box_hit", 32'(m_axis_tdata[100]),
                                        32'(want.box_hit));
                end
            end
        end
    end

    // The driver presents the next request at the falling edge once the current
    // one is gone. A request flagged drain_first waits for the output to empty.
    always @(negedge i_clk) begin
        if (rst_done) begin
            if (!s_vld || took) begin
                took = 1'b0;
                if (pending_reqs.size() > 0
                        && !(pending_reqs[0].drain_first && expected_vecs.size() > 0)
                        && (no_gaps || $urandom_range(99) >= 27)) begin
                    in_flight = pending_reqs.pop_front();
                    s_vld <= 1'b1;
                    s_data <= {6'd0, in_flight.vz, in_flight.vy, in_flight.vx,
                               in_flight.word_val, in_flight.word_sel,
                               in_flight.map_sel, in_flight.action};
                end else begin
                    s_vld <= 1'b0;
                end
            end
            m_rdy <= no_gaps || $urandom_range(99) >= 27;
        end
    end

    function automatic t_warp_req load_req(int m, int w, logic signed [31:0] v);
        t_warp_req q;
        q = '{pavw_pkg::ACT_LOAD, m[3:0], w[4:0], v, $urandom, $urandom, $urandom, 1'b0};
        return q;
    endfunction

    function automatic t_warp_req vec_req(logic signed [31:0] x, logic signed [31:0] y,
            logic signed [31:0] z);
        t_warp_req q;
        q = '{ACT_WARP, 4'($urandom), 5'($urandom), $urandom, x, y, z, 1'b0};
        return q;
    endfunction

    // Coefficient values shaped so that results mostly stay in range and boxes
    // are hit now and then; a few words take the full range.
    function automatic logic signed [31:0] coef_word(int w);
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) return $urandom;
        if (w < 9 || (w >= 12 && w < 21))
            return ((w % 12) % 4 == 0 ? 32'sh10000 : 32'sh0)
                 + $signed(32'($urandom_range(65536))) - 32'sd32768;
        if (w < 24) return $signed(32'($urandom_range(1 << 22))) - 32'sd2097152;
        if (w < 27) return -$signed(32'($urandom_range(1 << 23)));
        return $signed(32'($urandom_range(1 << 23)));
    endfunction

    function automatic logic signed [31:0] coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return $urandom;
        if (pick < 14) return pick[0] ? 32'sh7fffffff : 32'sh80000000;
        return $signed(32'($urandom_range(1 << 24))) - 32'sd8388608;
    endfunction

    // Waits until no request is queued or outstanding, plus time for a last load.
    task automatic wait_quiet();
        do begin
            @(negedge i_clk);
            #1;
        end while (pending_reqs.size() > 0 || s_vld || expected_vecs.size() > 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_val <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == pavw_pkg::REG_KIND) kind_shadow = val;
        else dir_shadow = val[0];
    endtask

    task automatic fill_table();
        for (int m = 0; m < MAPS; m++)
            for (int w = 0; w < pavw_pkg::WORDS_PER_MAP; w++)
                pending_reqs.push_back(load_req(m, w, coef_word(w)));
    endtask

    initial begin
        t_warp_req q;
        logic [1:0] kinds [5];
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        // Identity right after reset, at the corners of the coordinate range.
        pending_reqs.push_back(vec_req(32'sh7fffffff, 32'sh80000000, 32'sh0));
        pending_reqs.push_back(vec_req(32'sh80000000, 32'sh7fffffff, 32'shffffffff));
        pending_reqs.push_back(vec_req(32'sh00010000, 32'sh0, 32'sh7fffffff));
        wait_quiet();

        // Every table word is written before any map is used.
        fill_table();
        // Loads outside the table must leave it untouched.
        pending_reqs.push_back(load_req(15, 3, 32'sh7fffffff));
        pending_reqs.push_back(load_req(12, 0, 32'sh80000000));
        pending_reqs.push_back(load_req(2, 31, 32'sh12345678));
        pending_reqs.push_back(load_req(0, 30, 32'shffffffff));
        // Map 0 gets an exact tie in rounding and a saturating row.
        pending_reqs.push_back(load_req(0, 0, 32'sh00008000));
        pending_reqs.push_back(load_req(0, 3, 32'sh7fffffff));
        wait_quiet();

        kinds = '{pavw_pkg::KIND_AFFINE, pavw_pkg::KIND_BOXES, 2'd3,
                  pavw_pkg::KIND_IDENT, pavw_pkg::KIND_BOXES};
        foreach (kinds[p]) begin
            for (int d = 0; d < 2; d++) begin
                write_reg(pavw_pkg::REG_KIND, kinds[p]);
                write_reg(pavw_pkg::REG_DIR, d ? 2'b11 : 2'b00);
                pending_reqs.push_back(vec_req(32'sh00000001, 32'sh0, 32'sh0));
                pending_reqs.push_back(vec_req(32'sh00010000, 32'sh00020000, 32'shfffe0000));
                pending_reqs.push_back(vec_req(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
                pending_reqs.push_back(vec_req(32'sh80000000, 32'sh80000000, 32'sh80000000));
                wait_quiet();
            end
        end

        // Random phases: each picks a setting, reloads part of the table and
        // mixes loads with transforms. One phase runs with no gaps at all.
        for (int ph = 0; ph < 12; ph++) begin
            no_gaps = (ph == 4);
            write_reg(pavw_pkg::REG_KIND, (ph % 6 == 5) ? 2'd3 : 2'($urandom_range(2)));
            write_reg(pavw_pkg::REG_DIR, 2'($urandom_range(3)));
            for (int i = 0; i < 128; i++) begin
                if ($urandom_range(99) < 45) begin
                    if ($urandom_range(99) < 5)
                        q = load_req($urandom_range(15), $urandom_range(31), $urandom);
                    else
                        q = load_req($urandom_range(MAPS - 1), $urandom_range(29), 0);
                    if (q.map_sel < MAPS && q.word_sel < pavw_pkg::WORDS_PER_MAP)
                        q.word_val = coef_word(q.word_sel);
                end else begin
                    q = vec_req(coord(), coord(), coord());
                    q.drain_first = ($urandom_range(99) < 3);
                end
                pending_reqs.push_back(q);
            end
            wait_quiet();
        end
        no_gaps = 1'b0;

        if (fail_count == 0) begin
            $display("PASS piecewise_affine_vector_warp");
        end else begin
            $display("FAIL piecewise_affine_vector_warp");
        end
        $finish;
    end
endmodule
